>>> hdl/oldq_pkg.sv
// Package with request and response types and the codes of the ordered deque.
`timescale 1ns / 1ps
package oldq_pkg;

  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_DELETE     = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
  } rsp_t;

endpackage

>>> hdl/ordered_list_deque_with_delete.sv
// Top level of the bounded ordered deque with delete by value.
//
// Requests arrive as beats on req (req_valid/req_ready) and each request
// returns exactly one beat on rsp (rsp_valid/rsp_ready) carrying a status and
// the entry count after the request. The entries live in a single-port-write,
// registered-read memory, and one small sequencer walks it one entry at a time.
// The block takes one request at a time; req_ready is high only while the
// sequencer is idle.
// Steps from the accepted request to the raised rsp_valid:
//   push back, pop back, errors, unknown modes: straight to the done step.
//   push front: a read and a write per entry moved up, then the front write.
//   pop front: a read and a write per later entry moved down.
//   delete by value: a read and a compare per entry up to the hit or the end,
//   then a read and a write per entry moved down to close the gap.
// The memory read is registered, so the sequencer reads in one step and
// compares the data or writes it back in the next.
// A finished response waits in the output register while rsp_ready is low;
// the sequencer holds in its last step until that register is free.
// Reset (rst, synchronous) empties the list and drops any pending response.
`timescale 1ns / 1ps
module ordered_list_deque_with_delete
  import oldq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SHUP_RD  = 3'd1;
  localparam logic [2:0] S_SHUP_WR  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CMP = 3'd4;
  localparam logic [2:0] S_SHDN_RD  = 3'd5;
  localparam logic [2:0] S_SHDN_WR  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata;

  logic [2:0]             state, state_next;
  logic [CW-1:0]          count, count_next;
  logic [CW-1:0]          idx, idx_next;
  logic [VALUE_WIDTH-1:0] val, val_next;
  logic [1:0]             st, st_next;
  logic                   rsp_valid_next;
  rsp_t                   rsp_next;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [VALUE_WIDTH-1:0] wdata;

  logic [63:0]            req_sext;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [CW-1:0]          idx_dec, idx_inc;
  logic [CW+4:0]          count_wide;
  logic                   out_free;

  assign req_sext   = {{32{req.item_value[31]}}, req.item_value};
  assign req_val    = req_sext[VALUE_WIDTH-1:0];
  assign idx_dec    = idx - ONE;
  assign idx_inc    = idx + ONE;
  assign count_wide = {5'b0, count_next};
  assign out_free   = !rsp_valid || rsp_ready;
  assign req_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    val_next       = val;
    st_next        = st;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    we             = 1'b0;
    re             = 1'b0;
    waddr          = idx[AW-1:0];
    raddr          = idx[AW-1:0];
    wdata          = rdata;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next   = req_val;
          st_next    = ST_OK;
          idx_next   = '0;
          state_next = S_DONE;
          case (req.mode)
            MODE_PUSH_FRONT: begin
              if (count >= CAP_COUNT) begin
                st_next = ST_FULL;
              end else begin
                idx_next   = count;
                state_next = S_SHUP_RD;
              end
            end
            MODE_PUSH_BACK: begin
              if (count >= CAP_COUNT) begin
                st_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = req_val;
                count_next = count + ONE;
              end
            end
            MODE_POP_FRONT: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else begin
                state_next = S_SHDN_RD;
              end
            end
            MODE_POP_BACK: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else begin
                count_next = count - ONE;
              end
            end
            MODE_DELETE: begin
              if (count == '0) begin
                st_next = ST_EMPTY;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            default: begin
              st_next = ST_OK;
            end
          endcase
        end
      end

      // Move entries up by one, from the back toward the front, then drop the
      // new value into the front cell.
      S_SHUP_RD: begin
        if (idx == '0) begin
          we         = 1'b1;
          waddr      = '0;
          wdata      = val;
          count_next = count + ONE;
          state_next = S_DONE;
        end else begin
          re         = 1'b1;
          raddr      = idx_dec[AW-1:0];
          state_next = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        idx_next   = idx_dec;
        state_next = S_SHUP_RD;
      end

      S_SCAN_RD: begin
        if (idx >= count) begin
          st_next    = ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          re         = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (rdata == val) begin
          state_next = S_SHDN_RD;
        end else begin
          idx_next   = idx_inc;
          state_next = S_SCAN_RD;
        end
      end

      // Close the gap at idx by moving every later entry down by one.
      S_SHDN_RD: begin
        if (idx_inc >= count) begin
          count_next = count - ONE;
          state_next = S_DONE;
        end else begin
          re         = 1'b1;
          raddr      = idx_inc[AW-1:0];
          state_next = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        we         = 1'b1;
        waddr      = idx[AW-1:0];
        idx_next   = idx_inc;
        state_next = S_SHDN_RD;
      end

      S_DONE: begin
        if (out_free) begin
          rsp_valid_next       = 1'b1;
          rsp_next.status      = st;
          rsp_next.entry_count = count_wide[4:0];
          state_next           = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    val <= val_next;
    st  <= st_next;
    rsp <= rsp_next;
  end

endmodule
